@@ hw/rtl/ple_pkg.sv @@
// package for the positional list engine: command, status and cell control types
// no dependencies

package ple_pkg;

    localparam int unsigned DepthDefault = 128;
    localparam int unsigned DataW        = 32;
    localparam int unsigned PosW         = 8;
    localparam int unsigned CmdW         = 3;
    localparam int unsigned StatusW      = 2;

    typedef enum logic [CmdW-1:0] {
        CMD_GET    = 3'd0,
        CMD_SET    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_REMOVE = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [StatusW-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_WRITE      = 2'd1,
        OP_SHIFT_UP   = 2'd2,
        OP_SHIFT_DOWN = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [PosW-1:0]     idx;
        logic [DataW-1:0]    value;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/ple_if.sv @@
// valid/ready channel interfaces for the request and response sides
// depends on ple_pkg for field widths

interface ple_req_if;
    import ple_pkg::*;
    logic               valid;
    logic               ready;
    logic [CmdW-1:0]    cmd;
    logic [PosW-1:0]    position;
    logic signed [DataW-1:0] value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface ple_rsp_if;
    import ple_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [DataW-1:0] read_value;
    logic [StatusW-1:0]      status;
    logic [PosW-1:0]         count;
    logic                    is_empty;
    logic                    is_full;

    modport source (output valid, output read_value, output status, output count,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    input is_empty, input is_full, output ready);
endinterface

@@ hw/rtl/positional_list_engine.sv @@
// top level of the positional list engine: command decode, cell chain, response register
// depends on ple_pkg, ple_if and ple_cell

// The list is a row of DEPTH cells, one entry each, addressed by 1-based
// position. Insert and remove move all later entries by one cell in the
// same edge, and get reads through an and-or select across the row. A new
// request is taken in every cycle in which the response register is empty
// or its transfer completes, so the engine sustains one command per cycle.
// Entries start undefined; clear only drops the count.

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int unsigned DEPTH = DepthDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ple_req_if.sink       i_req,
    ple_rsp_if.source     o_rsp
);

    localparam logic [PosW-1:0] DepthVal = PosW'(DEPTH);

    logic                    r_out_valid;
    logic [DataW-1:0]        r_read_value;
    t_status                 r_status;
    logic [PosW-1:0]         r_count;
    logic [PosW-1:0]         r_out_count;

    logic [DataW-1:0]        n_read_value;
    t_status                 n_status;
    logic [PosW-1:0]         n_count;

    logic                    w_fire;
    logic                    w_pos_ok;
    logic                    w_ins_ok;
    logic                    w_full;
    logic [DataW-1:0]        w_rd_sel;
    t_cell_ctrl              w_ctrl;
    logic [DataW-1:0]        w_data    [DEPTH];
    logic [DataW-1:0]        w_rd_data [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_fire      = i_req.valid && i_req.ready;

    assign w_pos_ok = (i_req.position != '0) && (i_req.position <= r_count);
    assign w_ins_ok = (i_req.position != '0) &&
                      ({1'b0, i_req.position} <= ({1'b0, r_count} + 9'd1));
    assign w_full   = (r_count >= DepthVal);

    always_comb begin
        w_rd_sel = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_sel = w_rd_sel | w_rd_data[k];
        end
    end

    always_comb begin
        n_read_value = '0;
        n_status     = ST_OK;
        n_count      = r_count;
        w_ctrl.op    = OP_HOLD;
        w_ctrl.idx   = i_req.position - PosW'(1);
        w_ctrl.value = i_req.value;
        case (t_cmd'(i_req.cmd))
            CMD_GET: begin
                if (w_pos_ok) n_read_value = w_rd_sel;
                else begin
                    n_status     = ST_BAD_POS;
                    n_read_value = '1;
                end
            end
            CMD_SET: begin
                if (w_pos_ok) w_ctrl.op = OP_WRITE;
                else n_status = ST_BAD_POS;
            end
            CMD_INSERT: begin
                if (w_full) n_status = ST_FULL;
                else if (!w_ins_ok) n_status = ST_BAD_POS;
                else begin
                    w_ctrl.op = OP_SHIFT_UP;
                    n_count   = r_count + PosW'(1);
                end
            end
            CMD_REMOVE: begin
                if (r_count == '0) n_status = ST_EMPTY;
                else if (!w_pos_ok) n_status = ST_BAD_POS;
                else begin
                    w_ctrl.op = OP_SHIFT_DOWN;
                    n_count   = r_count - PosW'(1);
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: n_count = r_count;
        endcase
        if (!w_fire) w_ctrl.op = OP_HOLD;
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [DataW-1:0] w_left;
        logic [DataW-1:0] w_right;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right = w_data[k];
        end else begin : g_mid_r
            assign w_right = w_data[k+1];
        end
        ple_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_left    (w_left),
            .i_right   (w_right),
            .o_data    (w_data[k]),
            .o_rd_data (w_rd_data[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_out_count  <= n_count;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_read_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.count      = r_out_count;
    assign o_rsp.is_empty   = (r_out_count == '0);
    assign o_rsp.is_full    = (r_out_count == DepthVal);

endmodule

@@ hw/rtl/ple_cell.sv @@
// one storage cell of the list chain: holds one entry, takes a neighbor on shifts
// depends on ple_pkg

module ple_cell
    import ple_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [DataW-1:0] i_left,
    input  logic [DataW-1:0] i_right,
    output logic [DataW-1:0] o_data,
    output logic [DataW-1:0] o_rd_data
);

    localparam logic [PosW-1:0] K = PosW'(CELL_IDX);

    logic [DataW-1:0] r_data;
    logic [DataW-1:0] n_data;
    logic             w_hit;
    logic             w_above;

    assign w_hit   = (i_ctrl.idx == K);
    assign w_above = (K > i_ctrl.idx);

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            OP_WRITE: begin
                if (w_hit) n_data = i_ctrl.value;
            end
            OP_SHIFT_UP: begin
                if (w_hit) n_data = i_ctrl.value;
                else if (w_above) n_data = i_left;
            end
            OP_SHIFT_DOWN: begin
                if (w_hit || w_above) n_data = i_right;
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data    = r_data;
    assign o_rd_data = w_hit ? r_data : '0;

endmodule

@@ tb/sv/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps
// self-checking testbench for positional_list_engine: directed table, then random episodes
// depends on ple_pkg, ple_if and the engine rtl; checks every response against the directed table or its own list model

module tb_positional_list_engine;
    import ple_pkg::*;

    localparam int unsigned DEPTH        = DepthDefault;
    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned TAIL_CYCLES  = 16;
    localparam int unsigned PRINT_LIMIT  = 100;
    localparam int unsigned NUM_DIR      = 25;

    localparam logic [CmdW-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CmdW-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CmdW-1:0] CMD_RSVD_7 = 3'd7;

    localparam logic signed [DataW-1:0] READ_FAIL = -1;
    localparam logic signed [DataW-1:0] VAL_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [DataW-1:0] VAL_MIN   = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DataW-1:0] read_value;
        t_status                 status;
        logic [PosW-1:0]         count;
        logic                    is_empty;
        logic                    is_full;
    } t_rsp_item;

    typedef struct packed {
        logic [CmdW-1:0]         cmd;
        logic [PosW-1:0]         pos;
        logic signed [DataW-1:0] val;
        logic                    typed;
        logic signed [DataW-1:0] rd;
        t_status                 st;
        logic [PosW-1:0]         cnt;
    } t_dir_row;

    typedef enum {EP_FILL, EP_GROW, EP_DRAIN, EP_MIXED} t_episode;

    // rows with typed = 0 take their expectation from the list model
    t_dir_row dir_tab [NUM_DIR] = '{
        '{CMD_GET,    8'd1,   32'sd0,        1'b1, READ_FAIL, ST_BAD_POS, 8'd0},
        '{CMD_REMOVE, 8'd1,   32'sd0,        1'b1, 32'sd0,    ST_EMPTY,   8'd0},
        '{CMD_SET,    8'd1,   32'sd5,        1'b1, 32'sd0,    ST_BAD_POS, 8'd0},
        '{CMD_INSERT, 8'd0,   32'sd7,        1'b1, 32'sd0,    ST_BAD_POS, 8'd0},
        '{CMD_INSERT, 8'd2,   32'sd7,        1'b1, 32'sd0,    ST_BAD_POS, 8'd0},
        '{CMD_INSERT, 8'd1,   VAL_MAX,       1'b1, 32'sd0,    ST_OK,      8'd1},
        '{CMD_INSERT, 8'd2,   VAL_MIN,       1'b1, 32'sd0,    ST_OK,      8'd2},
        '{CMD_INSERT, 8'd1,   32'sd0,        1'b1, 32'sd0,    ST_OK,      8'd3},
        '{CMD_GET,    8'd2,   32'sd0,        1'b1, VAL_MAX,   ST_OK,      8'd3},
        '{CMD_GET,    8'd3,   READ_FAIL,     1'b1, VAL_MIN,   ST_OK,      8'd3},
        '{CMD_GET,    8'd4,   32'sd0,        1'b1, READ_FAIL, ST_BAD_POS, 8'd3},
        '{CMD_GET,    8'd0,   32'sd0,        1'b1, READ_FAIL, ST_BAD_POS, 8'd3},
        '{CMD_GET,    8'd255, 32'sd0,        1'b1, READ_FAIL, ST_BAD_POS, 8'd3},
        '{CMD_SET,    8'd3,   READ_FAIL,     1'b1, 32'sd0,    ST_OK,      8'd3},
        '{CMD_GET,    8'd3,   32'sd0,        1'b0, 32'sd0,    ST_OK,      8'd0},
        '{CMD_INSERT, 8'd4,   32'sh55AA55AA, 1'b0, 32'sd0,    ST_OK,      8'd0},
        '{CMD_INSERT, 8'd6,   32'sd1,        1'b1, 32'sd0,    ST_BAD_POS, 8'd4},
        '{CMD_REMOVE, 8'd0,   32'sd0,        1'b1, 32'sd0,    ST_BAD_POS, 8'd4},
        '{CMD_REMOVE, 8'd5,   32'sd0,        1'b1, 32'sd0,    ST_BAD_POS, 8'd4},
        '{CMD_REMOVE, 8'd1,   32'sd0,        1'b0, 32'sd0,    ST_OK,      8'd0},
        '{CMD_GET,    8'd1,   32'sd0,        1'b0, 32'sd0,    ST_OK,      8'd0},
        '{CMD_RSVD_5, 8'd255, READ_FAIL,     1'b1, 32'sd0,    ST_OK,      8'd3},
        '{CMD_RSVD_7, 8'd128, 32'sd0,        1'b1, 32'sd0,    ST_OK,      8'd3},
        '{CMD_CLEAR,  8'd1,   32'sd0,        1'b1, 32'sd0,    ST_OK,      8'd0},
        '{CMD_GET,    8'd1,   32'sd0,        1'b1, READ_FAIL, ST_BAD_POS, 8'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ple_req_if req_ch ();
    ple_rsp_if rsp_ch ();

    positional_list_engine #(
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #6 i_clk = ~i_clk;

    logic signed [DataW-1:0] list_mem [DEPTH];
    int unsigned             list_len;
    t_rsp_item               rsp_expect [$];
    int unsigned             error_count = 0;
    int unsigned             rsp_seen = 0;
    int unsigned             cycle_count = 0;
    int unsigned             burst_left;

    function automatic t_rsp_item apply_command(input logic [CmdW-1:0] cmd,
                                                input logic [PosW-1:0] pos,
                                                input logic signed [DataW-1:0] val);
        t_rsp_item   r;
        int unsigned n;
        int unsigned p;
        r.read_value = '0;
        r.status     = ST_OK;
        n            = list_len;
        p            = pos;
        case (cmd)
            CMD_GET: begin
                if (p < 1 || p > n) begin
                    r.status     = ST_BAD_POS;
                    r.read_value = READ_FAIL;
                end else begin
                    r.read_value = list_mem[p-1];
                end
            end
            CMD_SET: begin
                if (p < 1 || p > n) r.status = ST_BAD_POS;
                else list_mem[p-1] = val;
            end
            CMD_INSERT: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (p < 1 || p > n + 1) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (int i = n; i >= int'(p); i--) list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = val;
                    list_len      = n + 1;
                end
            end
            CMD_REMOVE: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 1 || p > n) begin
                    r.status = ST_BAD_POS;
                end else begin
                    for (int i = p - 1; i + 1 < n; i++) list_mem[i] = list_mem[i+1];
                    list_len = n - 1;
                end
            end
            CMD_CLEAR: list_len = 0;
            default: ;
        endcase
        r.count    = list_len[PosW-1:0];
        r.is_empty = (list_len == 0);
        r.is_full  = (list_len == DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [DataW-1:0] got,
                                   input logic [DataW-1:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: response %0d %s got %h expected %h", $time, rsp_seen, field, got,
                     want);
    endtask

    task automatic issue_command(input logic [CmdW-1:0] cmd, input logic [PosW-1:0] pos,
                                 input logic signed [DataW-1:0] val, input bit typed,
                                 input t_rsp_item want);
        int unsigned gap;
        t_rsp_item   pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= cmd;
        req_ch.position <= pos;
        req_ch.value    <= val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pred = apply_command(cmd, pos, val);
        rsp_expect.push_back(typed ? want : pred);
        burst_left--;
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (rsp_expect.size() != 0);
    endtask

    task automatic pick_command(input t_episode ep, output logic [CmdW-1:0] cmd,
                                output logic [PosW-1:0] pos,
                                output logic signed [DataW-1:0] val);
        int unsigned roll;
        int unsigned hi;
        roll = $urandom_range(0, 99);
        case (ep)
            EP_FILL:  cmd = (roll < 90) ? CMD_INSERT : (roll < 95) ? CMD_GET : CMD_SET;
            EP_GROW:  cmd = (roll < 50) ? CMD_INSERT : (roll < 65) ? CMD_REMOVE :
                            (roll < 82) ? CMD_GET : CMD_SET;
            EP_DRAIN: cmd = (roll < 60) ? CMD_REMOVE : (roll < 72) ? CMD_INSERT :
                            (roll < 88) ? CMD_GET : CMD_SET;
            default: begin
                if (roll < 25)      cmd = CMD_INSERT;
                else if (roll < 50) cmd = CMD_REMOVE;
                else if (roll < 72) cmd = CMD_GET;
                else if (roll < 92) cmd = CMD_SET;
                else if (roll < 95) cmd = CMD_CLEAR;
                else                cmd = CmdW'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
            end
        endcase
        hi   = (cmd == CMD_INSERT && list_len < DEPTH) ? list_len + 1 : list_len;
        roll = $urandom_range(0, 99);
        if (roll < 8 || hi == 0) pos = PosW'($urandom_range(0, 255));
        else if (roll < 12)      pos = '0;
        else if (roll < 16)      pos = PosW'(hi + 1);
        else if (roll < 23)      pos = PosW'(1);
        else if (roll < 30)      pos = PosW'(hi);
        else                     pos = PosW'($urandom_range(1, hi));
        roll = $urandom_range(0, 99);
        if (roll < 3)       val = VAL_MAX;
        else if (roll < 6)  val = VAL_MIN;
        else if (roll < 8)  val = READ_FAIL;
        else if (roll < 10) val = '0;
        else                val = $urandom;
    endtask

    // receiver: ready pattern changes every window
    int unsigned stall_mode;
    int unsigned stall_win;
    int unsigned stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 64);
            stall_win  = 0;
        end
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            2:       rsp_ch.ready <= ((stall_win % 3) == 0);
            default: rsp_ch.ready <= ((stall_win % 12) == 11);
        endcase
        stall_win++;
        stall_left--;
    end

    // response checker
    always @(posedge i_clk) begin
        t_rsp_item want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_expect.size() == 0) begin
                report_mismatch("transfer with nothing outstanding", '0, '0);
            end else begin
                want = rsp_expect.pop_front();
                if (rsp_ch.read_value !== want.read_value)
                    report_mismatch("read_value", rsp_ch.read_value, want.read_value);
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", DataW'(rsp_ch.status), DataW'(want.status));
                if (rsp_ch.count !== want.count)
                    report_mismatch("count", DataW'(rsp_ch.count), DataW'(want.count));
                if (rsp_ch.is_empty !== want.is_empty)
                    report_mismatch("is_empty", DataW'(rsp_ch.is_empty),
                                    DataW'(want.is_empty));
                if (rsp_ch.is_full !== want.is_full)
                    report_mismatch("is_full", DataW'(rsp_ch.is_full), DataW'(want.is_full));
            end
            rsp_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_rsp_item         want;
        t_episode          ep;
        int unsigned       ep_len;
        int unsigned       ep_num;
        int unsigned       sent;
        logic [CmdW-1:0]   cmd;
        logic [PosW-1:0]   pos;
        logic signed [DataW-1:0] val;

        burst_left  = 0;
        list_len    = 0;
        foreach (list_mem[i]) list_mem[i] = '0;
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.cmd      <= CMD_GET;
        req_ch.position <= '0;
        req_ch.value    <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIR; r++) begin
            want.read_value = dir_tab[r].rd;
            want.status     = dir_tab[r].st;
            want.count      = dir_tab[r].cnt;
            want.is_empty   = (dir_tab[r].cnt == 0);
            want.is_full    = (dir_tab[r].cnt == DEPTH);
            issue_command(dir_tab[r].cmd, dir_tab[r].pos, dir_tab[r].val, dir_tab[r].typed,
                          want);
        end
        drain_responses();

        // first episode fills the list past full, later ones wander
        sent   = 0;
        ep_num = 0;
        while (sent < RANDOM_ITEMS) begin
            if (ep_num == 0) begin
                ep     = EP_FILL;
                ep_len = 170;
            end else begin
                ep     = t_episode'($urandom_range(0, 3));
                ep_len = $urandom_range(20, 150);
            end
            for (int k = 0; k < ep_len && sent < RANDOM_ITEMS; k++) begin
                pick_command(ep, cmd, pos, val);
                issue_command(cmd, pos, val, 1'b0, '0);
                sent++;
                if (sent == RANDOM_ITEMS / 2) drain_responses();
            end
            ep_num++;
        end

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
